### hw/rtl/skt_pkg.sv
package skt_pkg;

    localparam int DEPTH_DEF     = 256;
    localparam int KEY_WIDTH_DEF = 32;

    // Fixed widths of the command and result words
    localparam int CMD_W  = 3;
    localparam int KEY_W  = 32;
    localparam int POS_W  = 8;
    localparam int STAT_W = 2;
    localparam int IDX_W  = 9;
    localparam int FILL_W = 9;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_SEARCH = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_READ   = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_RED,
        S_APL
    } t_state;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic             cmp;
        logic             ins;
        logic             rem;
        logic [POS_W-1:0] pos;
    } t_cell_ctl;

endpackage

### hw/rtl/sorted_key_table_core.sv
// A command word accepted in idle steps the sequencer through compare, reduce
// and apply; the result strobe is registered from the apply state, and busy
// stays high until the sequencer is idle again. No new command word is taken
// until the whole cell row has done the compare, reduce and shift steps in turn.
// Reset (synchronous, active low) empties the table and idles the sequencer;
// stored keys keep no reset. Results cannot be stalled by the receiver.
module sorted_key_table_core #(
    parameter int DEPTH     = skt_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = skt_pkg::KEY_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [skt_pkg::CMD_W-1:0]     i_command,
    input  logic [skt_pkg::KEY_W-1:0]     i_key,
    input  logic [skt_pkg::POS_W-1:0]     i_position,
    output logic                          o_valid,
    output logic [skt_pkg::STAT_W-1:0]    o_status,
    output logic [skt_pkg::IDX_W-1:0]     o_found_index,
    output logic [skt_pkg::KEY_W-1:0]     o_key_out,
    output logic [skt_pkg::FILL_W-1:0]    o_fill
);

    localparam int KW = KEY_WIDTH;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > skt_pkg::POS_W) ? CW : skt_pkg::POS_W;

    skt_pkg::t_state r_state;
    skt_pkg::t_state n_state;

    logic [skt_pkg::CMD_W-1:0] r_cmd;
    logic [KW-1:0]             r_k;
    logic [skt_pkg::POS_W-1:0] r_pos;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic [CW-1:0]             r_at;
    logic                      r_hit;
    logic [KW-1:0]             r_rd;

    logic                          r_valid;
    logic [skt_pkg::STAT_W-1:0]    r_status;
    logic [skt_pkg::STAT_W-1:0]    n_status;
    logic [skt_pkg::IDX_W-1:0]     r_idx;
    logic [skt_pkg::IDX_W-1:0]     n_idx;
    logic [skt_pkg::KEY_W-1:0]     r_kout;
    logic [skt_pkg::KEY_W-1:0]     n_kout;

    skt_pkg::t_cell_ctl w_ctl;

    logic [KW-1:0] w_cell_key [DEPTH];
    logic [KW-1:0] w_cell_rd  [DEPTH];
    logic          w_lt       [DEPTH];
    logic [DEPTH-1:0] w_bound;
    logic [DEPTH-1:0] w_hit;

    logic [CW-1:0] w_enc;
    logic [KW-1:0] w_rd_or;
    logic          w_any;
    logic          w_pos_ok;
    logic          w_room;

    assign busy = (r_state != skt_pkg::S_IDLE);

    // Position range check and free slot check against the current fill
    assign w_pos_ok = PW'(r_pos) < PW'(r_count);
    assign w_room   = r_count < CW'(DEPTH);

    // Cell row: each cell sees its left and right neighbors
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [KW-1:0] w_left_key;
        logic [KW-1:0] w_right_key;
        logic          w_left_lt;

        if (g == 0) begin : g_first
            assign w_left_key = w_cell_key[g];
            assign w_left_lt  = 1'b1;
        end else begin : g_mid
            assign w_left_key = w_cell_key[g-1];
            assign w_left_lt  = w_lt[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right_key = w_cell_key[g];
        end else begin : g_inner
            assign w_right_key = w_cell_key[g+1];
        end

        skt_cell #(
            .KW  (KW),
            .CW  (CW),
            .IDX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_key       (r_k),
            .i_count     (r_count),
            .i_left_key  (w_left_key),
            .i_left_lt   (w_left_lt),
            .i_right_key (w_right_key),
            .o_key       (w_cell_key[g]),
            .o_lt        (w_lt[g]),
            .o_bound     (w_bound[g]),
            .o_hit       (w_hit[g]),
            .o_rd        (w_cell_rd[g])
        );
    end

    // Reduce the per-cell flags: at most one cell marks the insertion point
    always_comb begin
        w_enc   = '0;
        w_rd_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_enc   = w_enc | (w_bound[i] ? CW'(i) : CW'(0));
            w_rd_or = w_rd_or | w_cell_rd[i];
        end
        w_any = |w_bound;
    end

    // Cell control: compare in S_CMP, shift in S_APL
    always_comb begin
        w_ctl.cmp = (r_state == skt_pkg::S_CMP);
        w_ctl.ins = (r_state == skt_pkg::S_APL) && (r_cmd == skt_pkg::CMD_INSERT)
                    && !r_hit && w_room;
        w_ctl.rem = (r_state == skt_pkg::S_APL) && (r_cmd == skt_pkg::CMD_REMOVE)
                    && w_pos_ok;
        w_ctl.pos = r_pos;
    end

    // Sequencer and result formation
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_status = skt_pkg::ST_MISS;
        n_idx    = '0;
        n_kout   = '0;
        case (r_state)
            skt_pkg::S_IDLE: begin
                if (start) n_state = skt_pkg::S_CMP;
            end
            skt_pkg::S_CMP: n_state = skt_pkg::S_RED;
            skt_pkg::S_RED: n_state = skt_pkg::S_APL;
            skt_pkg::S_APL: begin
                n_state = skt_pkg::S_IDLE;
                case (r_cmd)
                    skt_pkg::CMD_INSERT: begin
                        n_idx = skt_pkg::IDX_W'(r_at);
                        if (r_hit) begin
                            n_status = skt_pkg::ST_OK;
                        end else if (!w_room) begin
                            n_status = skt_pkg::ST_FULL;
                        end else begin
                            n_status = skt_pkg::ST_OK;
                            n_count  = CW'(r_count + 1'b1);
                        end
                    end
                    skt_pkg::CMD_SEARCH: begin
                        n_idx    = skt_pkg::IDX_W'(r_at);
                        n_status = r_hit ? skt_pkg::ST_OK : skt_pkg::ST_MISS;
                    end
                    skt_pkg::CMD_REMOVE: begin
                        n_idx = skt_pkg::IDX_W'(r_pos);
                        if (w_pos_ok) begin
                            n_status = skt_pkg::ST_OK;
                            n_count  = CW'(r_count - 1'b1);
                        end
                    end
                    skt_pkg::CMD_READ: begin
                        if (w_pos_ok) begin
                            n_status = skt_pkg::ST_OK;
                            n_kout   = skt_pkg::KEY_W'(r_rd);
                        end
                    end
                    skt_pkg::CMD_CLEAR: begin
                        n_status = skt_pkg::ST_OK;
                        n_count  = '0;
                    end
                    default: n_status = skt_pkg::ST_MISS;
                endcase
            end
            default: n_state = skt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skt_pkg::S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= (r_state == skt_pkg::S_APL);
        end
    end

    // Payload registers: capture the command word, the reduced flags, the result
    always_ff @(posedge i_clk) begin
        if (r_state == skt_pkg::S_IDLE && start) begin
            r_cmd <= i_command;
            r_k   <= KW'(i_key);
            r_pos <= i_position;
        end
        if (r_state == skt_pkg::S_RED) begin
            r_at  <= w_any ? w_enc : r_count;
            r_hit <= |w_hit;
            r_rd  <= w_rd_or;
        end
        if (r_state == skt_pkg::S_APL) begin
            r_status <= n_status;
            r_idx    <= n_idx;
            r_kout   <= n_kout;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_found_index = r_idx;
    assign o_key_out     = r_kout;
    assign o_fill        = skt_pkg::FILL_W'(r_count);

    // Accepted word always starts the sequencer
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // Result strobe only after the apply step
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == skt_pkg::S_APL))
        else $error("result strobe without apply step");

    // Fill never passes the table depth
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill beyond depth");

    // The sorted row has at most one insertion point
    a_one_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skt_pkg::S_RED) |-> $onehot0(w_bound))
        else $error("more than one insertion point");

endmodule

### hw/rtl/skt_cell.sv
module skt_cell #(
    parameter int KW  = skt_pkg::KEY_WIDTH_DEF,
    parameter int CW  = $clog2(skt_pkg::DEPTH_DEF + 1),
    parameter int IDX = 0
) (
    input  logic                i_clk,
    input  skt_pkg::t_cell_ctl  i_ctl,
    input  logic [KW-1:0]       i_key,
    input  logic [CW-1:0]       i_count,
    input  logic [KW-1:0]       i_left_key,
    input  logic                i_left_lt,
    input  logic [KW-1:0]       i_right_key,
    output logic [KW-1:0]       o_key,
    output logic                o_lt,
    output logic                o_bound,
    output logic                o_hit,
    output logic [KW-1:0]       o_rd
);

    logic [KW-1:0] r_key;
    logic [KW-1:0] n_key;
    logic          r_lt;
    logic          r_eq;
    logic          r_sel;
    logic          w_valid;

    assign w_valid = int'(i_count) > IDX;

    // Shift up on insert above the insertion point, down on remove
    always_comb begin
        n_key = r_key;
        if (i_ctl.ins && !r_lt) begin
            n_key = i_left_lt ? i_key : i_left_key;
        end
        if (i_ctl.rem && IDX >= int'(i_ctl.pos)) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        if (i_ctl.cmp) begin
            r_lt  <= w_valid && (r_key < i_key);
            r_eq  <= w_valid && (r_key == i_key);
            r_sel <= int'(i_ctl.pos) == IDX;
        end
    end

    assign o_key   = r_key;
    assign o_lt    = r_lt;
    assign o_bound = !r_lt && i_left_lt;
    assign o_hit   = o_bound && r_eq;
    assign o_rd    = r_sel ? r_key : '0;

endmodule

### tb/tb_sorted_key_table_core.sv
`timescale 1ns / 1ps

module tb_sorted_key_table_core;

    import skt_pkg::*;

    localparam int          TABLE_DEPTH      = DEPTH_DEF;
    localparam int          WATCHDOG_LIMIT   = 2000;
    localparam int          DRAIN_CYCLES     = 8;
    localparam int          MAX_PRINTED      = 40;
    localparam logic [2:0]  CMD_UNUSED_FIRST = 3'd5;
    localparam logic [31:0] KEY_MAX          = 32'hFFFF_FFFF;

    // One expected result word, at the widths of the result ports
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  found_index;
        logic [KEY_W-1:0]  key_out;
        logic [FILL_W-1:0] fill;
    } t_reply;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [CMD_W-1:0]   i_command;
    logic [KEY_W-1:0]   i_key;
    logic [POS_W-1:0]   i_position;
    logic               o_valid;
    logic [STAT_W-1:0]  o_status;
    logic [IDX_W-1:0]   o_found_index;
    logic [KEY_W-1:0]   o_key_out;
    logic [FILL_W-1:0]  o_fill;

    // Shadow copy of the sorted table and its fill count
    logic [KEY_W-1:0]   shadow_keys [TABLE_DEPTH];
    int unsigned        shadow_fill;

    t_reply             awaited_replies [$];
    int                 sender_idle_pct;
    int                 mismatch_count;
    int                 words_sent;
    int                 replies_checked;
    int                 full_rejects;
    int unsigned        peak_fill;
    int                 quiet_cycles;

    sorted_key_table_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_key         (i_key),
        .i_position    (i_position),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_key_out     (o_key_out),
        .o_fill        (o_fill)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow table
    // ------------------------------------------------------------------

    // Leftmost slot whose key is not below k, in 0..shadow_fill
    function automatic int unsigned leftmost_slot(input logic [KEY_W-1:0] k);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = shadow_fill;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (shadow_keys[mid] < k) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    // Apply one command word to the shadow table and return the reply it earns
    task automatic apply_to_shadow_table(input logic [CMD_W-1:0] cmd,
                                         input logic [KEY_W-1:0] k,
                                         input logic [POS_W-1:0] pos,
                                         output t_reply reply);
        int unsigned slot;
        bit          hit;
        reply = '0;
        reply.status = ST_MISS;
        case (cmd)
            CMD_INSERT: begin
                slot = leftmost_slot(k);
                hit  = (slot < shadow_fill) && (shadow_keys[slot] == k);
                reply.found_index = slot[IDX_W-1:0];
                if (hit) begin
                    reply.status = ST_OK;
                end else if (shadow_fill >= TABLE_DEPTH) begin
                    reply.status = ST_FULL;
                    full_rejects++;
                end else begin
                    // shift the higher entries up and drop the key in
                    for (int i = shadow_fill; i > slot; i--) begin
                        shadow_keys[i] = shadow_keys[i-1];
                    end
                    shadow_keys[slot] = k;
                    shadow_fill++;
                    reply.status = ST_OK;
                end
            end
            CMD_SEARCH: begin
                slot = leftmost_slot(k);
                hit  = (slot < shadow_fill) && (shadow_keys[slot] == k);
                reply.found_index = slot[IDX_W-1:0];
                reply.status = hit ? ST_OK : ST_MISS;
            end
            CMD_REMOVE: begin
                reply.found_index = {1'b0, pos};
                if (pos < shadow_fill) begin
                    shadow_fill--;
                    for (int i = pos; i < shadow_fill; i++) begin
                        shadow_keys[i] = shadow_keys[i+1];
                    end
                    reply.status = ST_OK;
                end
            end
            CMD_READ: begin
                if (pos < shadow_fill) begin
                    reply.key_out = shadow_keys[pos];
                    reply.status  = ST_OK;
                end
            end
            CMD_CLEAR: begin
                shadow_fill  = 0;
                reply.status = ST_OK;
            end
            default: begin
                // unused command codes change nothing
            end
        endcase
        reply.fill = shadow_fill[FILL_W-1:0];
        if (shadow_fill > peak_fill) begin
            peak_fill = shadow_fill;
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: one command word per call
    // ------------------------------------------------------------------

    // Call just after a rising edge. Leaves start high on return so the next
    // word can follow back to back.
    task automatic send_word(input logic [CMD_W-1:0] cmd,
                             input logic [KEY_W-1:0] k,
                             input logic [POS_W-1:0] pos);
        t_reply reply;
        // idle the command side at random, one cycle at a time
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_command  <= cmd;
        i_key      <= k;
        i_position <= pos;
        // hold the word until an edge sees start high and busy low
        do begin
            @(posedge i_clk);
        end while (busy);
        apply_to_shadow_table(cmd, k, pos, reply);
        awaited_replies.push_back(reply);
        words_sent++;
    endtask

    task automatic report_mismatch(input string field, input logic [KEY_W-1:0] got,
                                   input logic [KEY_W-1:0] want);
        if (mismatch_count < MAX_PRINTED) begin
            $display("[%0t] mismatch on %s: got %h, want %h (reply %0d)",
                     $realtime, field, got, want, replies_checked);
        end
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Result checker: the receiver never stalls, so take every strobe
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_valid) begin
            if (awaited_replies.size() == 0) begin
                report_mismatch("unexpected result strobe", {23'd0, o_found_index}, '0);
            end else begin
                want = awaited_replies.pop_front();
                if (o_status !== want.status) begin
                    report_mismatch("status", {30'd0, o_status}, {30'd0, want.status});
                end
                if (o_found_index !== want.found_index) begin
                    report_mismatch("found_index", {23'd0, o_found_index},
                                    {23'd0, want.found_index});
                end
                if (o_key_out !== want.key_out) begin
                    report_mismatch("key_out", o_key_out, want.key_out);
                end
                if (o_fill !== want.fill) begin
                    report_mismatch("fill", {23'd0, o_fill}, {23'd0, want.fill});
                end
            end
            replies_checked++;
        end
    end

    // Watchdog: end the run if nothing moves on either side for too long
    always @(posedge i_clk) begin
        if (i_rst_n && ((start && !busy) || o_valid)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog expired, %0d replies still awaited",
                     $realtime, awaited_replies.size());
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty-table misses, key extremes, duplicates, out-of-range indexes,
    // unused command codes and clear
    task automatic test_directed_edges();
        send_word(CMD_SEARCH, 32'd0, 8'd0);
        send_word(CMD_READ, KEY_MAX, 8'd0);
        send_word(CMD_REMOVE, KEY_MAX, 8'd0);
        send_word(CMD_INSERT, 32'h8000_0000, 8'hFF);
        send_word(CMD_INSERT, 32'd0, 8'd0);
        send_word(CMD_INSERT, KEY_MAX, 8'd0);
        send_word(CMD_INSERT, 32'h8000_0000, 8'd0);     // already present
        send_word(CMD_SEARCH, KEY_MAX, 8'd0);
        send_word(CMD_SEARCH, 32'h7FFF_FFFF, 8'd0);     // miss in the middle
        send_word(CMD_SEARCH, 32'hFFFF_FFFE, 8'd0);     // miss just below the top
        send_word(CMD_READ, 32'd0, 8'd2);
        send_word(CMD_READ, 32'd0, 8'd3);               // first index past the fill
        send_word(CMD_READ, 32'd0, 8'hFF);
        send_word(CMD_REMOVE, 32'd0, 8'hFF);
        send_word(CMD_REMOVE, 32'd0, 8'd1);
        send_word(CMD_READ, 32'd0, 8'd1);
        for (int c = 0; c < 3; c++) begin
            send_word(CMD_UNUSED_FIRST + c[2:0], $urandom, 8'($urandom_range(255)));
        end
        send_word(CMD_REMOVE, 32'd0, 8'd0);
        send_word(CMD_CLEAR, $urandom, 8'($urandom_range(255)));
        send_word(CMD_INSERT, 32'h5555_5555, 8'h55);
        send_word(CMD_INSERT, 32'hAAAA_AAAA, 8'hAA);
        send_word(CMD_CLEAR, 32'd0, 8'd0);
    endtask

    // Fill every slot, then hit the full-table cases and the edge indexes
    task automatic test_fill_to_capacity();
        logic [KEY_W-1:0] held;
        while (shadow_fill < TABLE_DEPTH) begin
            send_word(CMD_INSERT, $urandom, 8'($urandom_range(255)));
        end
        held = shadow_keys[$urandom_range(TABLE_DEPTH - 1)];
        send_word(CMD_INSERT, held, 8'd0);                  // present while full
        send_word(CMD_INSERT, $urandom, 8'd0);              // rejected as full
        send_word(CMD_INSERT, KEY_MAX, 8'd0);
        send_word(CMD_SEARCH, held, 8'd0);
        send_word(CMD_READ, 32'd0, 8'hFF);
        send_word(CMD_REMOVE, 32'd0, 8'hFF);
        send_word(CMD_READ, 32'd0, 8'hFF);                  // now past the fill
        send_word(CMD_REMOVE, 32'd0, 8'd0);
        send_word(CMD_READ, 32'd0, 8'd0);
        send_word(CMD_CLEAR, 32'd0, 8'd0);
    endtask

    // Mostly well-formed traffic: keys and indexes drawn from what the table
    // holds, with a share of random keys, stray indexes and odd commands
    task automatic test_random_mix(input int count);
        int               pick;
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] k;
        logic [POS_W-1:0] pos;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 42) begin
                cmd = CMD_INSERT;
            end else if (pick < 62) begin
                cmd = CMD_SEARCH;
            end else if (pick < 79) begin
                cmd = CMD_REMOVE;
            end else if (pick < 96) begin
                cmd = CMD_READ;
            end else if (pick < 98) begin
                cmd = CMD_CLEAR;
            end else begin
                cmd = CMD_UNUSED_FIRST + 3'($urandom_range(2));
            end

            // keys: present, a neighbor of one present, an extreme, or random
            k = $urandom;
            if (shadow_fill > 0) begin
                pick = $urandom_range(99);
                if (pick < 40) begin
                    k = shadow_keys[$urandom_range(shadow_fill - 1)];
                end else if (pick < 55) begin
                    k = shadow_keys[$urandom_range(shadow_fill - 1)]
                        + ($urandom_range(1) ? 32'd1 : KEY_MAX);
                end else if (pick < 60) begin
                    k = $urandom_range(1) ? KEY_MAX : 32'd0;
                end
            end

            // indexes: mostly inside the fill, sometimes anywhere
            pos = 8'($urandom_range(255));
            if (shadow_fill > 0 && $urandom_range(9) < 8) begin
                pos = 8'($urandom_range(shadow_fill - 1));
            end
            send_word(cmd, k, pos);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_command       <= CMD_INSERT;
        i_key           <= '0;
        i_position      <= '0;
        shadow_fill     = 0;
        sender_idle_pct = 7;
        mismatch_count  = 0;
        words_sent      = 0;
        replies_checked = 0;
        full_rejects    = 0;
        peak_fill       = 0;
        quiet_cycles    = 0;

        // hold reset, then release it at an edge
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        test_fill_to_capacity();

        // light sender gaps, then heavy gaps, then back to back
        test_random_mix(390);
        sender_idle_pct = 88;
        test_random_mix(390);
        sender_idle_pct = 0;
        test_random_mix(390);

        start <= 1'b0;
        while (awaited_replies.size() != 0) begin
            @(posedge i_clk);
        end
        // let any stray strobe show up before judging
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d command words and %0d replies; peak fill %0d of %0d,",
                 words_sent, replies_checked, peak_fill, TABLE_DEPTH);
        $display("  %0d inserts refused on a full table, %0d mismatches.",
                 full_rejects, mismatch_count);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/skt_pkg.sv
hw/rtl/skt_cell.sv
hw/rtl/sorted_key_table_core.sv
tb/tb_sorted_key_table_core.sv
